// ----- sv/frq_pkg.sv -----
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types, codes and the CRC-8 step for the frame receiver with queue.
// ----------------------------------------------------------------------------
package frq_pkg;

    // default sizing
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;

    // item commands
    typedef enum logic [1:0] {
        CMD_LINK = 2'd0,
        CMD_READ = 2'd1,
        CMD_POP  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [7:0] REG_FIRST_SYNC  = 8'd0;
    localparam logic [7:0] REG_SECOND_SYNC = 8'd1;
    localparam logic [7:0] REG_END_MARKER  = 8'd2;
    localparam logic [7:0] REG_CRC_POLY    = 8'd3;

    // register reset values
    localparam logic [7:0] FIRST_SYNC_RST  = 8'hAA;
    localparam logic [7:0] SECOND_SYNC_RST = 8'h55;
    localparam logic [7:0] END_MARKER_RST  = 8'h0D;
    localparam logic [7:0] CRC_POLY_RST    = 8'h07;

    // input word
    typedef struct packed {
        cmd_t       command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_word_t;

    // result word
    typedef struct packed {
        logic       frame_accepted;
        logic       frame_dropped;
        logic [2:0] queue_count;
        logic [7:0] head_command;
        logic [8:0] head_length;
        logic [7:0] read_data;
        logic       pop_ok;
    } out_word_t;

    // configuration write word
    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
    } cfg_word_t;

    // one byte of msb-first crc-8, no final xor
    function automatic logic [7:0] crc8_step(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/frq_stream_if.sv -----
// ----------------------------------------------------------------------------
// frq_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface frq_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- sv/frame_receiver_with_queue_top.sv -----
// ----------------------------------------------------------------------------
// frame_receiver_with_queue_top
// Takes one word per clock: a link byte, a payload read of the oldest queued
// frame, or a pop. Link bytes are deframed (two sync bytes, command, 16-bit
// length, payload, CRC-8, end marker) and good frames are queued in a ring
// of QUEUE_DEPTH frames that overwrites the oldest when full. Payload bytes
// are written straight into a spare slot of the payload memory as they
// arrive, so queueing a frame is only a pointer move. Every word gives one
// result word, through the p1 stage, where the payload memory read is
// registered, and then the output register. Sustained rate is one word per
// clock while the result side keeps up; one result can wait at the output
// while the next word is still taken.
// ----------------------------------------------------------------------------
module frame_receiver_with_queue_top
    import frq_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    frq_stream_if.sink   req,
    frq_stream_if.source rsp,
    frq_stream_if.sink   cfg
);

    // sizing
    localparam int NSLOT  = QUEUE_DEPTH + 1;
    localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int MEM_DEPTH = NSLOT << POS_W;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_SYNC    = 8'b0000_0010,
        PH_CMD     = 8'b0000_0100,
        PH_LEN_LO  = 8'b0000_1000,
        PH_LEN_HI  = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CRC     = 8'b0100_0000,
        PH_END     = 8'b1000_0000
    } phase_t;

    // next slot around the ring
    function automatic slot_t slot_inc(input slot_t s);
        return (s == SLOT_W'(NSLOT - 1)) ? '0 : s + 1'b1;
    endfunction

    // configuration registers
    logic [7:0] first_sync_reg;
    logic [7:0] second_sync_reg;
    logic [7:0] end_marker_reg;
    logic [7:0] crc_poly_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [7:0] fcmd_reg, fcmd_next;
    logic [7:0] len_lo_reg, len_lo_next;
    len_t       flen_reg, flen_next;
    len_t       pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] rcrc_reg, rcrc_next;

    // queue pointers; tail is the spare slot the parser fills
    slot_t          head_reg, head_next;
    slot_t          tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // per-slot header fields
    logic [7:0] slot_cmd_reg [NSLOT];
    len_t       slot_len_reg [NSLOT];

    // payload memory
    logic [7:0] pay_mem [MEM_DEPTH];
    logic [7:0] mem_q_reg;

    // pipeline and output stages
    logic      p1_valid_reg;
    out_word_t p1_word_reg, p1_word_next;
    logic      p1_hit_reg, p1_hit_next;
    logic      out_valid_reg;
    out_word_t out_word_reg, out_word_next;

    logic       accept;
    logic       p1_move;
    logic       push;
    logic       dropped;
    logic       pop_ok;
    logic       mem_we;
    logic [15:0] len_full;
    len_t       pos_inc;
    logic [7:0] rx_b;
    logic [7:0] ri;
    logic [7:0] head_cmd_fwd;
    len_t       head_len_fwd;
    logic [$clog2(MEM_DEPTH)-1:0] mem_waddr;
    logic [$clog2(MEM_DEPTH)-1:0] mem_raddr;

    assign rx_b     = req.payload.rx_byte;
    assign ri       = req.payload.read_index;
    assign len_full = {rx_b, len_lo_reg};
    assign pos_inc  = pos_reg + 1'b1;

    // handshakes
    assign p1_move   = p1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !p1_valid_reg || p1_move;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_word_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= FIRST_SYNC_RST;
            second_sync_reg <= SECOND_SYNC_RST;
            end_marker_reg  <= END_MARKER_RST;
            crc_poly_reg    <= CRC_POLY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_FIRST_SYNC:  first_sync_reg  <= cfg.payload.data;
                REG_SECOND_SYNC: second_sync_reg <= cfg.payload.data;
                REG_END_MARKER:  end_marker_reg  <= cfg.payload.data;
                REG_CRC_POLY:    crc_poly_reg    <= cfg.payload.data;
                default:         ;
            endcase
        end
    end

    // parser, queue pointers and command handling
    always_comb
    begin
        phase_next  = phase_reg;
        fcmd_next   = fcmd_reg;
        len_lo_next = len_lo_reg;
        flen_next   = flen_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        push        = 1'b0;
        dropped     = 1'b0;
        pop_ok      = 1'b0;
        mem_we      = 1'b0;
        p1_hit_next = 1'b0;
        if (accept)
        begin
            case (req.payload.command)
                CMD_LINK:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (rx_b == first_sync_reg)
                                phase_next = PH_SYNC;
                        end
                        PH_SYNC:
                        begin
                            phase_next = (rx_b == second_sync_reg) ? PH_CMD : PH_IDLE;
                        end
                        PH_CMD:
                        begin
                            fcmd_next  = rx_b;
                            crc_next   = crc8_step(8'h00, rx_b, crc_poly_reg);
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO:
                        begin
                            len_lo_next = rx_b;
                            crc_next    = crc8_step(crc_reg, rx_b, crc_poly_reg);
                            phase_next  = PH_LEN_HI;
                        end
                        PH_LEN_HI:
                        begin
                            crc_next = crc8_step(crc_reg, rx_b, crc_poly_reg);
                            pos_next = '0;
                            if (32'(len_full) > MAX_PAYLOAD)
                                phase_next = PH_IDLE;
                            else
                            begin
                                flen_next  = LEN_W'(len_full);
                                phase_next = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            mem_we   = 1'b1;
                            pos_next = pos_inc;
                            crc_next = crc8_step(crc_reg, rx_b, crc_poly_reg);
                            if (pos_inc >= flen_reg)
                                phase_next = PH_CRC;
                        end
                        PH_CRC:
                        begin
                            rcrc_next  = rx_b;
                            phase_next = PH_END;
                        end
                        PH_END:
                        begin
                            push       = (rx_b == end_marker_reg) && (crc_reg == rcrc_reg);
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                CMD_READ:
                begin
                    p1_hit_next = (count_reg != '0)
                               && (32'(ri) < 32'(slot_len_reg[head_reg]))
                               && (32'(ri) < MAX_PAYLOAD);
                end
                CMD_POP:
                begin
                    if (count_reg != '0)
                    begin
                        head_next  = slot_inc(head_reg);
                        count_next = count_reg - 1'b1;
                        pop_ok     = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // queue a finished frame; the spare slot joins the ring
            if (push)
            begin
                tail_next = slot_inc(tail_reg);
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    head_next = slot_inc(head_reg);
                    dropped   = 1'b1;
                end
                else
                    count_next = count_reg + 1'b1;
            end
        end
    end

    // head fields after this word, forwarding a frame queued in the same cycle
    always_comb
    begin
        if (push && (head_next == tail_reg))
        begin
            head_cmd_fwd = fcmd_reg;
            head_len_fwd = flen_reg;
        end
        else
        begin
            head_cmd_fwd = slot_cmd_reg[head_next];
            head_len_fwd = slot_len_reg[head_next];
        end
    end

    // result word, read data merged in one stage later
    always_comb
    begin
        p1_word_next.frame_accepted = push;
        p1_word_next.frame_dropped  = dropped;
        p1_word_next.queue_count    = 3'(count_next);
        p1_word_next.head_command   = (count_next != '0) ? head_cmd_fwd : 8'h00;
        p1_word_next.head_length    = (count_next != '0) ? 9'(head_len_fwd) : 9'd0;
        p1_word_next.read_data      = 8'h00;
        p1_word_next.pop_ok         = pop_ok;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            fcmd_reg   <= '0;
            len_lo_reg <= '0;
            flen_reg   <= '0;
            pos_reg    <= '0;
            crc_reg    <= '0;
            rcrc_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fcmd_reg   <= fcmd_next;
            len_lo_reg <= len_lo_next;
            flen_reg   <= flen_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            rcrc_reg   <= rcrc_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // slot header tables
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_cmd_reg[tail_reg] <= fcmd_reg;
            slot_len_reg[tail_reg] <= flen_reg;
        end
    end

    // payload memory: parser writes the spare slot, reads come from the head
    assign mem_waddr = {tail_reg, POS_W'(pos_reg)};
    assign mem_raddr = {head_reg, POS_W'(ri)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pay_mem[mem_waddr] <= rx_b;
        if (accept)
            mem_q_reg <= pay_mem[mem_raddr];
    end

    // pipeline stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                p1_valid_reg <= 1'b1;
            else if (p1_move)
                p1_valid_reg <= 1'b0;
            if (p1_move)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result word with the payload byte merged in
    always_comb
    begin
        out_word_next           = p1_word_reg;
        out_word_next.read_data = p1_hit_reg ? mem_q_reg : 8'h00;
    end

    // pipeline stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_word_reg <= p1_word_next;
            p1_hit_reg  <= p1_hit_next;
        end
        if (p1_move)
            out_word_reg <= out_word_next;
    end

    // checks
    logic [SLOT_W:0] ring_sum;
    slot_t           ring_tail;
    assign ring_sum  = {1'b0, head_reg} + (SLOT_W + 1)'(count_reg);
    assign ring_tail = (32'(ring_sum) >= NSLOT) ? SLOT_W'(32'(ring_sum) - NSLOT)
                                                : SLOT_W'(ring_sum);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count above depth");

    a_tail_follows_head: assert property (@(posedge clk) disable iff (!rst_n)
        ring_tail == tail_reg)
        else $error("spare slot not after last queued frame");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> p1_valid_reg)
        else $error("accepted word lost before result stage");

    a_drop_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dropped) |-> (push && count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("drop without full queue push");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (pos_reg < flen_reg))
        else $error("payload position past frame length");

endmodule
